>>> hw/rtl/clsc_pkg.sv
// Shared types and constants for the cluster light sphere culler.
// Used by clsc_plane_unit, the top level and the checker; depends on nothing.
`default_nettype none

package clsc_pkg;

    localparam int PLANES        = 6;
    localparam int MAX_LIGHTS_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int RADIUS_W      = 31;
    localparam int LIMIT_W       = 17;
    localparam int SLOT_W        = 16;
    localparam int LIDX_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int COUNT_CEIL    = 2047;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd65536;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // Request kinds carried on the input side-band.
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TEST  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_START = 2'd3
    } t_req;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } t_plane;

    // Per-stage load enables handed to the plane units.
    typedef struct packed {
        logic s1;
        logic s2;
    } t_pipe_en;

    typedef struct packed {
        t_req              req;
        logic              kind;
        logic [LIDX_W-1:0] lidx;
    } t_meta;

endpackage

`default_nettype wire

>>> hw/rtl/clsc_plane_unit.sv
// One plane of the sphere test: three products in the first stage, the
// signed sum against zero in the second. Depends on clsc_pkg.
`default_nettype none

module clsc_plane_unit #(
    parameter int FRAC_BITS = clsc_pkg::FRAC_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire clsc_pkg::t_pipe_en                i_en,
    input  wire clsc_pkg::t_plane                  i_plane,
    input  wire signed [clsc_pkg::COEF_W-1:0]      i_cx,
    input  wire signed [clsc_pkg::COEF_W-1:0]      i_cy,
    input  wire signed [clsc_pkg::COEF_W-1:0]      i_cz,
    input  wire        [clsc_pkg::RADIUS_W-1:0]    i_radius,
    output logic                                   o_pass
);

    localparam int ProdW = 2 * clsc_pkg::COEF_W;
    localparam int PW    = ProdW - FRAC_BITS;   // floored product width
    localparam int SW    = PW + 3;              // room for five terms

    logic signed [ProdW-1:0] prod_a, prod_b, prod_c;
    logic signed [PW-1:0]    r_pa, r_pb, r_pc;
    logic signed [clsc_pkg::COEF_W-1:0] r_d;
    logic signed [SW-1:0]    sum;

    // Dropping the low bits of a two's complement product floors it.
    assign prod_a = i_plane.a * i_cx;
    assign prod_b = i_plane.b * i_cy;
    assign prod_c = i_plane.c * i_cz;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pa <= prod_a[ProdW-1:FRAC_BITS];
            r_pb <= prod_b[ProdW-1:FRAC_BITS];
            r_pc <= prod_c[ProdW-1:FRAC_BITS];
            r_d  <= i_plane.d;
        end
    end

    assign sum = SW'(r_pa) + SW'(r_pb) + SW'(r_pc) + SW'(r_d)
               + $signed(SW'(i_radius));

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            o_pass <= !sum[SW-1] && (sum != '0);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cluster_light_sphere_culler_top.sv
// Top level of the cluster light sphere culler: request pipeline, plane store,
// index list bookkeeping and result register. Depends on clsc_pkg and clsc_plane_unit.
//
// Usage: the host streams requests on the slave channel. tuser carries the
// request kind (load plane, test light, close cluster, start frame) and tdata
// the plane, the light sphere and its index. Every request yields exactly one
// result on the master channel, in request order. A plane load takes effect for
// every test request accepted after it.
// From the accepting edge a request passes the input register, which loads at
// that edge, then the product stage of the six plane units, the sum and compare
// stage, and the result register where the list counters update. Throughput is
// one request per cycle while the receiver does not stall the pipeline; the
// eighteen products are formed in parallel, one multiplier per product.
// Each stage holds its request until the next stage can take it, so a stalled
// receiver first fills the empty stages and tready drops only when all four
// stages hold a request. A result waiting on the output does not block
// requests from entering while a stage behind it is free.
// The index limit is written over the configuration channel, which is always
// ready; write it only while no request is in flight.
// Synchronous active-low reset empties the pipeline, clears the planes, the
// list position, cluster counts and overflow flag, and sets the limit to 65536.
`default_nettype none

module cluster_light_sphere_culler_top #(
    parameter int MAX_LIGHTS = clsc_pkg::MAX_LIGHTS_DEF,
    parameter int FRAC_BITS  = clsc_pkg::FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Request channel.
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // From bit 0: plane_index[3], coef_a[32], coef_b[32], coef_c[32],
    // coef_d[32], center_x[32], center_y[32], center_z[32], radius[31],
    // light_kind[1], light_index[10], zero pad[3].
    input  wire  [clsc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // From bit 0: req_type[2].
    input  wire  [clsc_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // Result channel.
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // From bit 0: hit[1], index_position[16], hit_light_index[10],
    // cluster_start[16], point_count[11], spot_count[11], overflow[1],
    // zero pad[6].
    output logic [clsc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // Configuration channel: index_limit.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [clsc_pkg::LIMIT_W-1:0]        i_cfg_data
);

    localparam int CapInt = (MAX_LIGHTS < clsc_pkg::COUNT_CEIL) ?
                            MAX_LIGHTS : clsc_pkg::COUNT_CEIL;
    localparam logic [clsc_pkg::COUNT_W-1:0] CountCap = clsc_pkg::COUNT_W'(CapInt);

    // ---------------------------------------------------------------
    // Handshake and stage valids.
    // ---------------------------------------------------------------
    logic r_v0, r_v1, r_v2, r_vo;
    logic rdy0, rdy1, rdy2, rdy_o;
    logic accept, adv2;
    clsc_pkg::t_pipe_en pen;

    assign rdy_o  = !r_vo || i_m_axis_tready;
    assign rdy2   = !r_v2 || rdy_o;
    assign rdy1   = !r_v1 || rdy2;
    assign rdy0   = !r_v0 || rdy1;
    assign adv2   = r_v2 && rdy_o;
    assign accept = i_s_axis_tvalid && rdy0;

    assign o_s_axis_tready = rdy0;
    assign o_m_axis_tvalid = r_vo;
    assign o_cfg_ready     = 1'b1;
    assign pen.s1 = rdy1;
    assign pen.s2 = rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy0)  r_v0 <= i_s_axis_tvalid;
            if (rdy1)  r_v1 <= r_v0;
            if (rdy2)  r_v2 <= r_v1;
            if (rdy_o) r_vo <= r_v2;
        end
    end

    // ---------------------------------------------------------------
    // Input field unpacking.
    // ---------------------------------------------------------------
    logic [2:0]                        in_slot;
    clsc_pkg::t_plane                  in_plane;
    logic [clsc_pkg::COEF_W-1:0]       in_cx, in_cy, in_cz;
    logic [clsc_pkg::RADIUS_W-1:0]     in_radius;
    clsc_pkg::t_meta                   in_meta;

    assign in_slot      = i_s_axis_tdata[2:0];
    assign in_plane.a   = i_s_axis_tdata[34:3];
    assign in_plane.b   = i_s_axis_tdata[66:35];
    assign in_plane.c   = i_s_axis_tdata[98:67];
    assign in_plane.d   = i_s_axis_tdata[130:99];
    assign in_cx        = i_s_axis_tdata[162:131];
    assign in_cy        = i_s_axis_tdata[194:163];
    assign in_cz        = i_s_axis_tdata[226:195];
    assign in_radius    = i_s_axis_tdata[257:227];
    assign in_meta.kind = i_s_axis_tdata[258];
    assign in_meta.lidx = i_s_axis_tdata[268:259];
    assign in_meta.req  = clsc_pkg::t_req'(i_s_axis_tuser);

    // ---------------------------------------------------------------
    // Plane store. A load writes at its accepting edge, so every test that
    // is accepted later reads the new plane in its product stage, and a test
    // already in flight has taken its products by then.
    // ---------------------------------------------------------------
    clsc_pkg::t_plane r_plane [clsc_pkg::PLANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < clsc_pkg::PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (accept && in_meta.req == clsc_pkg::REQ_LOAD) begin
            for (int p = 0; p < clsc_pkg::PLANES; p++) begin
                if (in_slot == 3'(p)) begin
                    r_plane[p] <= in_plane;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0 (input register), stage 1 and stage 2 side information.
    // ---------------------------------------------------------------
    logic signed [clsc_pkg::COEF_W-1:0] r0_cx, r0_cy, r0_cz;
    logic [clsc_pkg::RADIUS_W-1:0]      r0_radius, r1_radius;
    clsc_pkg::t_meta                    r0_meta, r1_meta, r2_meta;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r0_cx     <= in_cx;
            r0_cy     <= in_cy;
            r0_cz     <= in_cz;
            r0_radius <= in_radius;
            r0_meta   <= in_meta;
        end
        if (rdy1) begin
            r1_radius <= r0_radius;
            r1_meta   <= r0_meta;
        end
        if (rdy2) begin
            r2_meta <= r1_meta;
        end
    end

    logic [clsc_pkg::PLANES-1:0] pass;

    for (genvar g = 0; g < clsc_pkg::PLANES; g++) begin : g_plane
        clsc_plane_unit #(
            .FRAC_BITS (FRAC_BITS)
        ) u_plane (
            .i_clk    (i_clk),
            .i_en     (pen),
            .i_plane  (r_plane[g]),
            .i_cx     (r0_cx),
            .i_cy     (r0_cy),
            .i_cz     (r0_cz),
            .i_radius (r1_radius),
            .o_pass   (pass[g])
        );
    end

    // ---------------------------------------------------------------
    // List bookkeeping and result register.
    // ---------------------------------------------------------------
    logic [clsc_pkg::LIMIT_W-1:0] r_limit, r_gc, n_gc;
    logic [clsc_pkg::SLOT_W-1:0]  r_start, n_start;
    logic [clsc_pkg::COUNT_W-1:0] r_pc, n_pc, r_sc, n_sc;
    logic                         r_ovf, n_ovf;
    logic                         all_pass, store_ok;

    logic                         n_hit, r_hit;
    logic [clsc_pkg::SLOT_W-1:0]  n_pos, r_pos, n_cstart, r_cstart;
    logic [clsc_pkg::LIDX_W-1:0]  n_lidx, r_lidx;
    logic [clsc_pkg::COUNT_W-1:0] n_opc, r_opc, n_osc, r_osc;
    logic                         r_oovf;

    assign all_pass = &pass;
    assign store_ok = all_pass && !r_ovf && (r_gc < r_limit);

    always_comb begin
        n_gc     = r_gc;
        n_start  = r_start;
        n_pc     = r_pc;
        n_sc     = r_sc;
        n_ovf    = r_ovf;
        n_hit    = 1'b0;
        n_pos    = '0;
        n_lidx   = '0;
        n_cstart = '0;
        n_opc    = '0;
        n_osc    = '0;
        unique case (r2_meta.req)
            clsc_pkg::REQ_LOAD: begin
                n_gc = r_gc;
            end
            clsc_pkg::REQ_TEST: begin
                n_hit = all_pass;
                if (store_ok) begin
                    n_pos  = r_gc[clsc_pkg::SLOT_W-1:0];
                    n_lidx = r2_meta.lidx;
                    n_gc   = r_gc + 1'b1;
                    if (r2_meta.kind) begin
                        if (r_sc < CountCap) n_sc = r_sc + 1'b1;
                    end else begin
                        if (r_pc < CountCap) n_pc = r_pc + 1'b1;
                    end
                end
                if (n_gc >= r_limit) n_ovf = 1'b1;
            end
            clsc_pkg::REQ_CLOSE: begin
                n_cstart = r_start;
                n_opc    = r_pc;
                n_osc    = r_sc;
                // Past the last slot the next start saturates.
                n_start  = r_gc[clsc_pkg::SLOT_W] ? '1 : r_gc[clsc_pkg::SLOT_W-1:0];
                n_pc     = '0;
                n_sc     = '0;
            end
            clsc_pkg::REQ_START: begin
                n_gc    = '0;
                n_start = '0;
                n_pc    = '0;
                n_sc    = '0;
                n_ovf   = 1'b0;
            end
            default: begin
                n_gc = r_gc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= clsc_pkg::LIMIT_MAX;
            r_gc    <= '0;
            r_start <= '0;
            r_pc    <= '0;
            r_sc    <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                // Limits above the list size act as the list size.
                r_limit <= (i_cfg_data > clsc_pkg::LIMIT_MAX) ? clsc_pkg::LIMIT_MAX
                                                              : i_cfg_data;
            end
            if (adv2) begin
                r_gc    <= n_gc;
                r_start <= n_start;
                r_pc    <= n_pc;
                r_sc    <= n_sc;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_hit    <= n_hit;
            r_pos    <= n_pos;
            r_lidx   <= n_lidx;
            r_cstart <= n_cstart;
            r_opc    <= n_opc;
            r_osc    <= n_osc;
            r_oovf   <= n_ovf;
        end
    end

    assign o_m_axis_tdata = {6'b0, r_oovf, r_osc, r_opc, r_cstart, r_lidx, r_pos, r_hit};

endmodule

`default_nettype wire

>>> hw/rtl/clsc_checker.sv
// Port-level checks for the cluster light sphere culler, bound to the top level.
// Depends on clsc_pkg and cluster_light_sphere_culler_top.
`default_nettype none

module clsc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_s_axis_tready,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [clsc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    logic hit_bit, list_fields, close_fields;

    assign hit_bit      = o_m_axis_tdata[0];
    assign list_fields  = (o_m_axis_tdata[16:1] != '0) || (o_m_axis_tdata[26:17] != '0);
    assign close_fields = (o_m_axis_tdata[42:27] != '0) || (o_m_axis_tdata[53:43] != '0)
                       || (o_m_axis_tdata[64:54] != '0);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline, so the block takes requests right after.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    // Requests are refused only when every stage is full behind a stalled result.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("request refused with room in the pipeline");

    // A list slot is only ever reported for a hit.
    a_slot_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && list_fields |-> hit_bit)
        else $error("list slot reported without a hit");

    // Cluster summaries never carry test fields.
    a_close_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && close_fields |-> !hit_bit && !list_fields)
        else $error("close result mixed with test fields");

endmodule

bind cluster_light_sphere_culler_top clsc_checker u_clsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> tb/tb_cluster_light_sphere_culler_top.sv
// Self-checking testbench for cluster_light_sphere_culler_top: directed table and
// random clusters, checked against typed results or an in-bench culling predictor.
// Depends on clsc_pkg and the culler RTL only.

module tb_cluster_light_sphere_culler_top;

    localparam int          CYCLE_LIMIT = 200_000;
    localparam int          LONG_HOLD   = 300;
    localparam int          DRAIN_WAIT  = 8;
    localparam int          DIR_ROWS    = 26;
    localparam logic [10:0] COUNT_CAP   =
        (clsc_pkg::MAX_LIGHTS_DEF < clsc_pkg::COUNT_CEIL) ? 11'(clsc_pkg::MAX_LIGHTS_DEF)
                                                          : 11'(clsc_pkg::COUNT_CEIL);

    // Handy Q16.16 constants for the directed table.
    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] FIVE    = 32'h0005_0000;
    localparam logic [31:0] TEN     = 32'h000A_0000;
    localparam logic [31:0] HUNDRED = 32'h0064_0000;

    typedef struct packed {
        clsc_pkg::t_req op;
        logic [2:0]     slot;
        logic [31:0]    ca, cb, cc, cd;
        logic [31:0]    cx, cy, cz;
        logic [30:0]    rad;
        logic           spot;
        logic [9:0]     lidx;
    } t_culler_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] pos;
        logic [9:0]  lidx;
        logic [15:0] cstart;
        logic [10:0] pcount;
        logic [10:0] scount;
        logic        ovf;
    } t_culler_result;

    typedef struct packed {
        t_culler_req    req;
        logic           known;
        t_culler_result res;
    } t_directed_row;

    localparam t_culler_result NO_RES = '0;

    logic                            i_clk;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic [clsc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic [clsc_pkg::IN_USER_W-1:0]  s_tuser   = '0;
    logic                            m_tready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [clsc_pkg::LIMIT_W-1:0]    cfg_data  = '0;
    wire                             o_s_axis_tready;
    wire                             o_m_axis_tvalid;
    wire  [clsc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    wire                             o_cfg_ready;

    cluster_light_sphere_culler_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // Predictor state: plane store, list position, open cluster and the limit register.
    clsc_pkg::t_plane planes [clsc_pkg::PLANES] = '{default: '0};
    logic [16:0]    list_fill     = '0;
    logic [15:0]    cluster_first = '0;
    logic [10:0]    point_tally   = '0;
    logic [10:0]    spot_tally    = '0;
    logic           overflow_seen = 1'b0;
    logic [16:0]    limit_reg     = clsc_pkg::LIMIT_MAX;

    t_culler_result pending_results [$];
    t_directed_row  directed [DIR_ROWS];
    int             error_count  = 0;
    int             result_count = 0;
    int             cycle_count  = 0;
    int             holds_asked  = 0;
    int             holds_done   = 0;
    bit             steady       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit sphere_clears(t_culler_req q);
        longint s;
        for (int p = 0; p < clsc_pkg::PLANES; p++) begin
            // Each product is floored to Q16.16 by the arithmetic shift.
            s = ((longint'($signed(planes[p].a)) * longint'($signed(q.cx)))
                    >>> clsc_pkg::FRAC_BITS_DEF)
              + ((longint'($signed(planes[p].b)) * longint'($signed(q.cy)))
                    >>> clsc_pkg::FRAC_BITS_DEF)
              + ((longint'($signed(planes[p].c)) * longint'($signed(q.cz)))
                    >>> clsc_pkg::FRAC_BITS_DEF)
              + longint'($signed(planes[p].d)) + longint'({1'b0, q.rad});
            if (s <= 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_culler_result predict_culler(t_culler_req q);
        t_culler_result res;
        logic [16:0]    lim;
        bit             in_box;
        res = '0;
        lim = (limit_reg > clsc_pkg::LIMIT_MAX) ? clsc_pkg::LIMIT_MAX : limit_reg;
        case (q.op)
            clsc_pkg::REQ_LOAD: begin
                if (q.slot < clsc_pkg::PLANES)
                    planes[q.slot] = '{a: q.ca, b: q.cb, c: q.cc, d: q.cd};
            end
            clsc_pkg::REQ_TEST: begin
                in_box  = sphere_clears(q);
                res.hit = in_box;
                if (in_box && !overflow_seen && list_fill < lim) begin
                    res.pos  = list_fill[15:0];
                    res.lidx = q.lidx;
                    list_fill++;
                    // The slot is taken even when the per-cluster count is pinned.
                    if (q.spot) begin
                        if (spot_tally < COUNT_CAP) spot_tally++;
                    end else begin
                        if (point_tally < COUNT_CAP) point_tally++;
                    end
                end
                if (list_fill >= lim) overflow_seen = 1'b1;
            end
            clsc_pkg::REQ_CLOSE: begin
                res.cstart    = cluster_first;
                res.pcount    = point_tally;
                res.scount    = spot_tally;
                cluster_first = (list_fill > 17'h0FFFF) ? 16'hFFFF : list_fill[15:0];
                point_tally   = '0;
                spot_tally    = '0;
            end
            default: begin
                list_fill     = '0;
                cluster_first = '0;
                point_tally   = '0;
                spot_tally    = '0;
                overflow_seen = 1'b0;
            end
        endcase
        res.ovf = overflow_seen;
        return res;
    endfunction

    // Appends one expected result behind those still outstanding.
    function automatic void queue_expected(t_culler_result r);
        pending_results = {pending_results, r};
    endfunction

    function automatic t_culler_req plane_req(logic [2:0] slot, logic [31:0] a, logic [31:0] b,
                                              logic [31:0] c, logic [31:0] d);
        t_culler_req q;
        q      = '0;
        q.op   = clsc_pkg::REQ_LOAD;
        q.slot = slot;
        q.ca   = a;
        q.cb   = b;
        q.cc   = c;
        q.cd   = d;
        return q;
    endfunction

    function automatic t_culler_req light_req(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic [30:0] r, logic spot, logic [9:0] lidx);
        t_culler_req q;
        q      = '0;
        q.op   = clsc_pkg::REQ_TEST;
        q.cx   = x;
        q.cy   = y;
        q.cz   = z;
        q.rad  = r;
        q.spot = spot;
        q.lidx = lidx;
        return q;
    endfunction

    function automatic t_culler_req control_req(clsc_pkg::t_req op);
        t_culler_req q;
        q    = '0;
        q.op = op;
        return q;
    endfunction

    function automatic t_culler_result typed_res(logic hit, logic [15:0] pos, logic [9:0] lidx,
                                                 logic [15:0] cstart, logic [10:0] pc,
                                                 logic [10:0] sc, logic ovf);
        return '{hit: hit, pos: pos, lidx: lidx, cstart: cstart, pcount: pc, scount: sc,
                 ovf: ovf};
    endfunction

    // Plane normal component in [-1.0, 1.0] and a sphere center coordinate in [-40.0, 40.0].
    function automatic logic [31:0] near_unit();
        return 32'($urandom_range(0, 131072)) - 32'd65536;
    endfunction

    function automatic logic [31:0] near_origin();
        return 32'($urandom_range(0, 80 << 16)) - 32'(40 << 16);
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long gap.
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(input t_culler_req q, input logic known,
                            input t_culler_result typed);
        t_culler_result predicted;
        int             gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.op;
        s_tdata  <= {3'b000, q.lidx, q.spot, q.rad, q.cz, q.cy, q.cx, q.cd, q.cc, q.cb, q.ca,
                     q.slot};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // The request was taken at this edge; the predictor follows in acceptance order.
        predicted = predict_culler(q);
        queue_expected(known ? typed : predicted);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // Mostly complete clusters (optional start frame, six planes, some lights, close),
    // the rest fully random requests.
    task automatic run_sequences(input int budget);
        t_culler_req q;
        int          sent;
        int          tests;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_req(control_req(clsc_pkg::REQ_START), 1'b0, NO_RES);
                    sent++;
                end
                for (int k = 0; k < clsc_pkg::PLANES; k++) begin
                    send_req(plane_req(3'(k), near_unit(), near_unit(), near_unit(),
                                       32'($urandom_range(0, 60 << 16))), 1'b0, NO_RES);
                end
                tests = $urandom_range(1, 10);
                repeat (tests) begin
                    send_req(light_req(near_origin(), near_origin(), near_origin(),
                                       31'($urandom_range(0, 10 << 16)), 1'($urandom),
                                       10'($urandom)), 1'b0, NO_RES);
                end
                send_req(control_req(clsc_pkg::REQ_CLOSE), 1'b0, NO_RES);
                sent += clsc_pkg::PLANES + tests + 1;
            end else begin
                q.op   = clsc_pkg::t_req'($urandom_range(0, 3));
                q.slot = 3'($urandom);
                q.ca   = $urandom;
                q.cb   = $urandom;
                q.cc   = $urandom;
                q.cd   = $urandom;
                q.cx   = $urandom;
                q.cy   = $urandom;
                q.cz   = $urandom;
                q.rad  = 31'($urandom);
                q.spot = 1'($urandom);
                q.lidx = 10'($urandom);
                send_req(q, 1'b0, NO_RES);
                if (!(q.op == clsc_pkg::REQ_LOAD && q.slot >= clsc_pkg::PLANES)) sent++;
            end
        end
    endtask

    // Result sink: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge i_clk);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_culler_result got;
        t_culler_result want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got.hit    = o_m_axis_tdata[0];
            got.pos    = o_m_axis_tdata[16:1];
            got.lidx   = o_m_axis_tdata[26:17];
            got.cstart = o_m_axis_tdata[42:27];
            got.pcount = o_m_axis_tdata[53:43];
            got.scount = o_m_axis_tdata[64:54];
            got.ovf    = o_m_axis_tdata[65];
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result %0d arrived with no request outstanding", result_count);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"result %0d mismatch (exp/got): hit %0b/%0b pos %0d/%0d ",
                                  "lidx %0d/%0d start %0d/%0d points %0d/%0d spots %0d/%0d ",
                                  "ovf %0b/%0b"},
                                 result_count, want.hit, got.hit, want.pos, got.pos,
                                 want.lidx, got.lidx, want.cstart, got.cstart,
                                 want.pcount, got.pcount, want.scount, got.scount,
                                 want.ovf, got.ovf);
                end
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_cluster_light_sphere_culler_top failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Planes are all zero after reset, so a sphere hits exactly when its radius is
        // positive; those rows carry their result directly.
        directed = '{
            '{light_req(32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 10'd0), 1'b1,
              typed_res(1'b0, 16'd0, 10'd0, 16'd0, 11'd0, 11'd0, 1'b0)},
            '{light_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 31'h1, 1'b0, 10'd1023),
              1'b1, typed_res(1'b1, 16'd0, 10'd1023, 16'd0, 11'd0, 11'd0, 1'b0)},
            '{light_req(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 1'b1, 10'd0), 1'b1,
              typed_res(1'b1, 16'd1, 10'd0, 16'd0, 11'd0, 11'd0, 1'b0)},
            '{control_req(clsc_pkg::REQ_CLOSE), 1'b1,
              typed_res(1'b0, 16'd0, 10'd0, 16'd0, 11'd1, 11'd1, 1'b0)},
            // Loads into the two spare slot codes must leave the store untouched.
            '{plane_req(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
              1'b1, NO_RES},
            '{plane_req(3'd7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              1'b1, NO_RES},
            '{light_req(ONE, ONE, ONE, 31'h1, 1'b1, 10'd512), 1'b1,
              typed_res(1'b1, 16'd2, 10'd512, 16'd0, 11'd0, 11'd0, 1'b0)},
            // A 20x20 box in x and y, depth 0 to 100.
            '{plane_req(3'd0, ONE, 32'h0, 32'h0, TEN), 1'b0, NO_RES},
            '{plane_req(3'd1, NEG_ONE, 32'h0, 32'h0, TEN), 1'b0, NO_RES},
            '{plane_req(3'd2, 32'h0, ONE, 32'h0, TEN), 1'b0, NO_RES},
            '{plane_req(3'd3, 32'h0, NEG_ONE, 32'h0, TEN), 1'b0, NO_RES},
            '{plane_req(3'd4, 32'h0, 32'h0, ONE, 32'h0), 1'b0, NO_RES},
            '{plane_req(3'd5, 32'h0, 32'h0, NEG_ONE, HUNDRED), 1'b0, NO_RES},
            '{light_req(32'h0, 32'h0, FIVE, 31'(ONE), 1'b0, 10'd12), 1'b0, NO_RES},
            '{light_req(32'h0014_0000, 32'h0, FIVE, 31'(ONE), 1'b0, 10'd13), 1'b0, NO_RES},
            // Sphere touching the x = 10 side exactly: the sum is zero, so it misses.
            '{light_req(32'h000A_8000, 32'h0, FIVE, 31'h8000, 1'b1, 10'd14), 1'b0, NO_RES},
            '{light_req(32'hFFF5_8000, 32'h0, FIVE, 31'h8001, 1'b1, 10'd15), 1'b0, NO_RES},
            // Half-unit normal against a small negative x: the product floors downward.
            '{plane_req(3'd0, 32'h0000_8001, 32'h0, 32'h0, TEN), 1'b0, NO_RES},
            '{light_req(32'hFFFF_FFFD, 32'h0, FIVE, 31'h0, 1'b0, 10'd16), 1'b0, NO_RES},
            '{plane_req(3'd5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              1'b0, NO_RES},
            '{light_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0, 1'b0, 10'd17),
              1'b0, NO_RES},
            '{plane_req(3'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
              1'b0, NO_RES},
            '{light_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1,
                        10'd18), 1'b0, NO_RES},
            '{control_req(clsc_pkg::REQ_CLOSE), 1'b0, NO_RES},
            '{control_req(clsc_pkg::REQ_START), 1'b1, NO_RES},
            '{control_req(clsc_pkg::REQ_CLOSE), 1'b1, NO_RES}
        };
        foreach (directed[i]) send_req(directed[i].req, directed[i].known, directed[i].res);

        // A zero limit overflows on the first test and never stores.
        settle();
        write_limit(17'd0);
        run_sequences(60);

        settle();
        write_limit(17'd1);
        run_sequences(80);

        // No idling on either side for this stretch.
        settle();
        steady = 1'b1;
        write_limit(17'd7);
        run_sequences(80);

        settle();
        steady = 1'b0;
        write_limit(17'($urandom_range(2, 200)));
        run_sequences(80);

        // The sink holds off for a long stretch while requests keep coming.
        settle();
        write_limit(clsc_pkg::LIMIT_MAX);
        holds_asked++;
        run_sequences(100);

        // An out-of-range limit acts as the full list size.
        settle();
        write_limit(17'h1FFFF);
        run_sequences(20);

        settle();
        if (error_count == 0) begin
            $display("tb_cluster_light_sphere_culler_top passed");
        end else begin
            $display("tb_cluster_light_sphere_culler_top failed");
        end
        $finish;
    end

endmodule
